### design/assert_macros.svh
// Assertion macros used by the top-level core of the xy-to-RGB converter.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CXR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CXR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cxr_pkg.sv
// Shared types, fixed-point constants and helper functions of the xy-to-RGB converter.
// No dependencies; every module of the block imports this package.
package cxr_pkg;

    localparam int COORD_BITS = 16;
    localparam int QF = 20;
    localparam int QW = 24;
    localparam int LUM_W = 21;

    typedef logic signed [QW-1:0] q_t;

    localparam q_t QONE = 24'sh100000;
    localparam q_t QMAX = 24'sh7FFFFF;
    localparam q_t QMIN = 24'sh800000;

    // Wide-gamut D65 XYZ-to-RGB matrix, each entry rounded to Q.20.
    localparam logic signed [21:0] C_RX = 22'sd1736958;
    localparam logic signed [21:0] C_RY = 22'sd372088;
    localparam logic signed [21:0] C_RZ = 22'sd267427;
    localparam logic signed [21:0] C_GX = 22'sd741549;
    localparam logic signed [21:0] C_GY = 22'sd1735810;
    localparam logic signed [21:0] C_GZ = 22'sd37908;
    localparam logic signed [21:0] C_BX = 22'sd54225;
    localparam logic signed [21:0] C_BY = 22'sd127259;
    localparam logic signed [21:0] C_BZ = 22'sd1060666;

    // Positive quotient to Q4.20 with saturation.
    function automatic q_t sat_pos(input logic [QW-1:0] q, input logic ovf);
        if (ovf || q[QW-1])
            return QMAX;
        return q_t'({1'b0, q[QW-2:0]});
    endfunction

    // Negated quotient magnitude to Q4.20 with saturation.
    function automatic q_t sat_neg(input logic [QW-1:0] q, input logic ovf);
        if (ovf || q > 24'h800000)
            return QMIN;
        return q_t'(-q);
    endfunction

    // Q.40 sum to Q.20, halves away from zero, saturated.
    function automatic q_t round_sat(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [28:0] rq;
        mag = v[47] ? 48'(-v) : 48'(v);
        rq = 29'((mag + 48'(1 << (QF - 1))) >> QF);
        if (!v[47])
            return (rq > 29'(QMAX)) ? QMAX : q_t'(rq[QW-1:0]);
        return (rq > 29'h800000) ? QMIN : q_t'(-rq[QW-1:0]);
    endfunction

endpackage

### design/cxr_div.sv
// Pipelined restoring divider with several lanes that share one divisor.
// A few quotient bits per stage; overflow is flagged at entry. Uses cxr_pkg.
module cxr_div
    import cxr_pkg::*;
#(
    parameter int LANES = 2,
    parameter int NUM_W = 38,
    parameter int DEN_W = 16,
    parameter int QB = 24,
    parameter int BPS = 4,
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [LANES-1:0][NUM_W-1:0]      in_num,
    input  logic [DEN_W-1:0]                 in_den,
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [LANES-1:0][QB-1:0]         out_q,
    output logic [LANES-1:0]                 out_ovf,
    output logic [SIDE_W-1:0]                out_side
);

    localparam int HI_W = NUM_W - QB;
    localparam int EXT_W = HI_W + DEN_W;
    localparam int NST = (QB + BPS - 1) / BPS;

    logic [NST:0]   v_reg;
    logic [NST+1:0] rdy;

    logic [LANES-1:0][DEN_W-1:0] rem_reg  [NST+1];
    logic [LANES-1:0][DEN_W-1:0] rem_next [NST+1];
    logic [LANES-1:0][QB-1:0]    lo_reg   [NST+1];
    logic [LANES-1:0][QB-1:0]    lo_next  [NST+1];
    logic [LANES-1:0]            ovf_reg  [NST+1];
    logic [LANES-1:0]            ovf_next;
    logic [DEN_W-1:0]            den_reg  [NST+1];
    logic [SIDE_W-1:0]           side_reg [NST+1];

    // A stage may load when it is empty or its content moves on.
    always_comb
    begin
        rdy[NST+1] = out_ready;
        for (int s = NST; s >= 0; s--)
            rdy[s] = !v_reg[s] || rdy[s+1];
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        logic [HI_W-1:0] hi;
        logic [DEN_W:0]  t;
        logic            ge;
        for (int l = 0; l < LANES; l++)
        begin
            hi = in_num[l][NUM_W-1:QB];
            ovf_next[l] = EXT_W'(hi) >= EXT_W'(in_den);
            rem_next[0][l] = DEN_W'(hi);
            lo_next[0][l] = in_num[l][QB-1:0];
        end
        for (int s = 1; s <= NST; s++)
        begin
            rem_next[s] = rem_reg[s-1];
            lo_next[s] = lo_reg[s-1];
            for (int l = 0; l < LANES; l++)
            begin
                for (int k = 0; k < BPS; k++)
                begin
                    if ((s - 1) * BPS + k < QB)
                    begin
                        t = {rem_next[s][l], lo_next[s][l][QB-1]};
                        ge = t >= {1'b0, den_reg[s-1]};
                        lo_next[s][l] = {lo_next[s][l][QB-2:0], ge};
                        rem_next[s][l] = ge ? DEN_W'(t - {1'b0, den_reg[s-1]}) : DEN_W'(t);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int s = 1; s <= NST; s++)
            begin
                if (rdy[s])
                    v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            rem_reg[0] <= rem_next[0];
            lo_reg[0] <= lo_next[0];
            ovf_reg[0] <= ovf_next;
            den_reg[0] <= in_den;
            side_reg[0] <= in_side;
        end
        for (int s = 1; s <= NST; s++)
        begin
            if (rdy[s] && v_reg[s-1])
            begin
                rem_reg[s] <= rem_next[s];
                lo_reg[s] <= lo_next[s];
                ovf_reg[s] <= ovf_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[NST];
    assign out_q = lo_reg[NST];
    assign out_ovf = ovf_reg[NST];
    assign out_side = side_reg[NST];

endmodule

### design/cxr_gamma_rom.sv
// Encoding-curve lookup table with a registered read port.
// The table is built at elaboration with exact integer arithmetic. Uses cxr_pkg.
module cxr_gamma_rom
    import cxr_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    output logic [7:0]        data
);

    localparam int TOP = (DEPTH > 1) ? DEPTH - 1 : 1;

    typedef logic [7:0] lut_t [DEPTH];

    function automatic logic [319:0] pw(input logic [319:0] base, input int n);
        logic [319:0] r;
        r = 320'd1;
        for (int k = 0; k < n; k++)
            r = r * base;
        return r;
    endfunction

    // True when 255 * (1.055 v^(5/12) - 0.055) reaches the code, v = i / TOP.
    function automatic logic reaches(input int unsigned i, input int unsigned code);
        logic [319:0] lhs;
        logic [319:0] rhs;
        lhs = pw(320'(i), 5) * pw(320'd269025, 12);
        rhs = pw(320'(1000 * code + 14025), 12) * pw(320'(TOP), 5);
        return lhs >= rhs;
    endfunction

    function automatic lut_t build_lut();
        lut_t t;
        int unsigned code;
        int unsigned v;
        code = 0;
        for (int unsigned i = 0; i < DEPTH; i++)
        begin
            if (64'(i) * 64'd10000000 <= 64'd31308 * 64'(TOP))
            begin
                // Linear segment near black.
                v = 0;
                while (v < 255 && 64'(v + 1) * 64'd10 * 64'(TOP) <= 64'd32946 * 64'(i))
                    v++;
                t[i] = 8'(v);
            end
            else
            begin
                while (code < 255 && reaches(i, code + 1))
                    code++;
                t[i] = 8'(code);
            end
        end
        return t;
    endfunction

    localparam lut_t LUT = build_lut();

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= LUT[addr];
    end

    assign data = data_reg;

endmodule

### design/cie_xy_to_rgb_gamma_core.sv
// CIE xy chromaticity plus brightness to gamma-encoded 8-bit RGB converter.
// Input stream s_*: one transfer carries chroma_x, chroma_y and brightness.
// Output stream m_*: one transfer per input carries red, green, blue and the
// bad_coordinate flag (set, with black, when chroma_y is zero).
// The block is a deep pipeline: luminance, X and Z division (pipelined, four
// quotient bits per stage), matrix products, sums, rounding, normalization
// division (pipelined, four bits per stage) and the registered curve lookup.
// Throughput is one item per cycle when the receiver never stalls.
// Each stage holds a valid bit and loads when it is empty or its content
// moves on, so a stall of m_tready fills the bubbles first and only then
// drops s_tready; nothing is lost or repeated.
// Reset clears all valid bits; the lookup table is constant and needs no
// loading, so the block takes items as soon as reset is released.
// Depends on cxr_pkg, cxr_div, cxr_gamma_rom and assert_macros.svh.
`include "assert_macros.svh"

module cie_xy_to_rgb_gamma_core
    import cxr_pkg::*;
#(
    parameter int GAMMA_LUT_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // chroma_x [15:0], chroma_y [31:16], brightness [39:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic [0:0]  m_tuser    // bad_coordinate [0]
);

    localparam int ADDR_W = $clog2(GAMMA_LUT_DEPTH);
    localparam logic [ADDR_W-1:0] LUT_TOP = ADDR_W'(GAMMA_LUT_DEPTH - 1);
    localparam int ZW = COORD_BITS + 2;
    localparam int ZM_W = COORD_BITS + 1;
    localparam int NXZ_W = LUM_W + ZM_W;
    localparam int XZ_SIDE_W = 2 + LUM_W;
    localparam int NN_W = QW - 1 + QF;
    localparam int N_SIDE_W = 4 + 3 * QW;
    localparam int IP_W = QF + ADDR_W + 2;

    // Stage a: input register.
    logic                  a_v_reg, a_rdy;
    logic [COORD_BITS-1:0] a_x_reg, a_y_reg;
    logic [7:0]            a_b_reg;

    // Stage b: luminance and z.
    logic                  b_v_reg, b_rdy;
    logic [LUM_W-1:0]      b_lum_reg;
    logic [COORD_BITS-1:0] b_x_reg, b_y_reg;
    logic                  b_zneg_reg, b_bad_reg;
    logic [ZM_W-1:0]       b_zmag_reg;
    logic [12:0]           lum_t;
    logic [22:0]           lum_p;
    logic [6:0]            lum_q1;
    logic [12:0]           lum_r;
    logic [6:0]            lum_frac;
    logic signed [ZW-1:0]  zc;

    // Stage c: numerators.
    logic                  c_v_reg, c_rdy;
    logic [NXZ_W-1:0]      c_mx_reg, c_mz_reg;
    logic [COORD_BITS-1:0] c_y_reg;
    logic [XZ_SIDE_W-1:0]  c_side_reg;

    // X and Z divider.
    logic                        dxz_in_ready, dxz_out_valid;
    logic [1:0][NXZ_W-1:0]       dxz_num;
    logic [1:0][QW-1:0]          dxz_q;
    logic [1:0]                  dxz_ovf;
    logic [XZ_SIDE_W-1:0]        dxz_side;

    // Stage e: saturated X, Z and Y.
    logic e_v_reg, e_rdy, e_bad_reg;
    q_t   e_cx_reg, e_cz_reg, e_lum_reg;

    // Stage f: matrix products.
    logic                f_v_reg, f_rdy, f_bad_reg;
    logic signed [45:0]  f_p_reg [9];

    // Stage g: channel sums.
    logic                g_v_reg, g_rdy, g_bad_reg;
    logic signed [47:0]  g_s_reg [3];

    // Stage h: rounded channels.
    logic h_v_reg, h_rdy, h_bad_reg;
    q_t   h_c_reg [3];

    // Stage i: normalization decision.
    logic                 i_v_reg, i_rdy;
    logic [2:0]           i_sel;
    logic [QW-2:0]        i_den_reg;
    logic [2:0][NN_W-1:0] i_num_reg;
    logic [N_SIDE_W-1:0]  i_side_reg;
    q_t                   i_max;

    // Normalization divider.
    logic                 dn_in_ready, dn_out_valid;
    logic [2:0][QF-1:0]   dn_q;
    logic [2:0]           dn_ovf;
    logic [N_SIDE_W-1:0]  dn_side;
    logic                 dn_bad;
    logic [2:0]           dn_sel;
    q_t                   dn_c [3];

    // Stage j: final linear channels.
    logic           j_v_reg, j_rdy, j_bad_reg;
    logic [2:0]     j_zero_reg, j_over_reg;
    logic [QF:0]    j_frac_reg [3];
    q_t             j_val [3];

    // Stage k: table index.
    logic              k_v_reg, k_rdy, k_bad_reg;
    logic [2:0]        k_zero_reg, k_over_reg;
    logic [ADDR_W-1:0] k_idx_reg [3];
    logic [IP_W-1:0]   k_prod [3];

    // Stage l: lookup and output.
    logic       l_v_reg, l_rdy, l_bad_reg;
    logic [2:0] l_zero_reg, l_over_reg;
    logic [7:0] l_data [3];
    logic [7:0] out_ch [3];

    // Ready chain, from the output back to the input.
    assign l_rdy = !l_v_reg || m_tready;
    assign k_rdy = !k_v_reg || l_rdy;
    assign j_rdy = !j_v_reg || k_rdy;
    assign i_rdy = !i_v_reg || dn_in_ready;
    assign h_rdy = !h_v_reg || i_rdy;
    assign g_rdy = !g_v_reg || h_rdy;
    assign f_rdy = !f_v_reg || g_rdy;
    assign e_rdy = !e_v_reg || f_rdy;
    assign c_rdy = !c_v_reg || dxz_in_ready;
    assign b_rdy = !b_v_reg || c_rdy;
    assign a_rdy = !a_v_reg || b_rdy;
    assign s_tready = a_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            j_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
            l_v_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy) a_v_reg <= s_tvalid;
            if (b_rdy) b_v_reg <= a_v_reg;
            if (c_rdy) c_v_reg <= b_v_reg;
            if (e_rdy) e_v_reg <= dxz_out_valid;
            if (f_rdy) f_v_reg <= e_v_reg;
            if (g_rdy) g_v_reg <= f_v_reg;
            if (h_rdy) h_v_reg <= g_v_reg;
            if (i_rdy) i_v_reg <= h_v_reg;
            if (j_rdy) j_v_reg <= dn_out_valid;
            if (k_rdy) k_v_reg <= j_v_reg;
            if (l_rdy) l_v_reg <= k_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && s_tvalid)
        begin
            a_x_reg <= s_tdata[COORD_BITS-1:0];
            a_y_reg <= s_tdata[16+COORD_BITS-1:16];
            a_b_reg <= s_tdata[39:32];
        end
    end

    // brightness * 2^20 / 254 = 4128 b + floor(32 b / 127).
    always_comb
    begin
        lum_t = {a_b_reg, 5'b0};
        lum_p = 23'(lum_t) * 23'd516;
        lum_q1 = lum_p[22:16];
        lum_r = 13'(lum_t - 13'(lum_q1) * 13'd127);
        lum_frac = (lum_r >= 13'd127) ? 7'(lum_q1 + 7'd1) : lum_q1;
        zc = ZW'(1 << COORD_BITS) - ZW'(a_x_reg) - ZW'(a_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (b_rdy && a_v_reg)
        begin
            b_lum_reg <= LUM_W'(a_b_reg) * LUM_W'(4128) + LUM_W'(lum_frac);
            b_x_reg <= a_x_reg;
            b_y_reg <= a_y_reg;
            b_zneg_reg <= zc[ZW-1];
            b_zmag_reg <= zc[ZW-1] ? ZM_W'(-zc) : ZM_W'(zc);
            b_bad_reg <= (a_y_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_rdy && b_v_reg)
        begin
            c_mx_reg <= NXZ_W'(b_lum_reg) * NXZ_W'(b_x_reg);
            c_mz_reg <= NXZ_W'(b_lum_reg) * NXZ_W'(b_zmag_reg);
            c_y_reg <= b_y_reg;
            c_side_reg <= {b_bad_reg, b_zneg_reg, b_lum_reg};
        end
    end

    assign dxz_num[0] = c_mx_reg;
    assign dxz_num[1] = c_mz_reg;

    cxr_div #(
        .LANES  (2),
        .NUM_W  (NXZ_W),
        .DEN_W  (COORD_BITS),
        .QB     (QW),
        .BPS    (4),
        .SIDE_W (XZ_SIDE_W)
    ) u_div_xz (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_v_reg),
        .in_ready  (dxz_in_ready),
        .in_num    (dxz_num),
        .in_den    (c_y_reg),
        .in_side   (c_side_reg),
        .out_valid (dxz_out_valid),
        .out_ready (e_rdy),
        .out_q     (dxz_q),
        .out_ovf   (dxz_ovf),
        .out_side  (dxz_side)
    );

    always_ff @(posedge clk)
    begin
        if (e_rdy && dxz_out_valid)
        begin
            e_cx_reg <= sat_pos(dxz_q[0], dxz_ovf[0]);
            e_cz_reg <= dxz_side[LUM_W] ? sat_neg(dxz_q[1], dxz_ovf[1])
                                        : sat_pos(dxz_q[1], dxz_ovf[1]);
            e_lum_reg <= q_t'(dxz_side[LUM_W-1:0]);
            e_bad_reg <= dxz_side[LUM_W+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_rdy && e_v_reg)
        begin
            f_p_reg[0] <= e_cx_reg * C_RX;
            f_p_reg[1] <= e_lum_reg * C_RY;
            f_p_reg[2] <= e_cz_reg * C_RZ;
            f_p_reg[3] <= e_cx_reg * C_GX;
            f_p_reg[4] <= e_lum_reg * C_GY;
            f_p_reg[5] <= e_cz_reg * C_GZ;
            f_p_reg[6] <= e_cx_reg * C_BX;
            f_p_reg[7] <= e_lum_reg * C_BY;
            f_p_reg[8] <= e_cz_reg * C_BZ;
            f_bad_reg <= e_bad_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_rdy && f_v_reg)
        begin
            g_s_reg[0] <= 48'(f_p_reg[0]) - 48'(f_p_reg[1]) - 48'(f_p_reg[2]);
            g_s_reg[1] <= 48'(f_p_reg[4]) + 48'(f_p_reg[5]) - 48'(f_p_reg[3]);
            g_s_reg[2] <= 48'(f_p_reg[6]) - 48'(f_p_reg[7]) + 48'(f_p_reg[8]);
            g_bad_reg <= f_bad_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_rdy && g_v_reg)
        begin
            for (int l = 0; l < 3; l++)
                h_c_reg[l] <= round_sat(g_s_reg[l]);
            h_bad_reg <= g_bad_reg;
        end
    end

    // Only a strictly largest channel above one scales the others.
    always_comb
    begin
        i_sel[0] = (h_c_reg[0] > h_c_reg[2]) && (h_c_reg[0] > h_c_reg[1])
                   && (h_c_reg[0] > QONE);
        i_sel[1] = (h_c_reg[1] > h_c_reg[2]) && (h_c_reg[1] > h_c_reg[0])
                   && (h_c_reg[1] > QONE);
        i_sel[2] = (h_c_reg[2] > h_c_reg[0]) && (h_c_reg[2] > h_c_reg[1])
                   && (h_c_reg[2] > QONE);
        i_max = i_sel[0] ? h_c_reg[0] : (i_sel[1] ? h_c_reg[1] : h_c_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (i_rdy && h_v_reg)
        begin
            for (int l = 0; l < 3; l++)
                i_num_reg[l] <= (h_c_reg[l] > 0) ? {h_c_reg[l][QW-2:0], QF'(0)} : '0;
            i_den_reg <= i_max[QW-2:0];
            i_side_reg <= {h_bad_reg, i_sel, h_c_reg[2], h_c_reg[1], h_c_reg[0]};
        end
    end

    cxr_div #(
        .LANES  (3),
        .NUM_W  (NN_W),
        .DEN_W  (QW - 1),
        .QB     (QF),
        .BPS    (4),
        .SIDE_W (N_SIDE_W)
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (i_v_reg),
        .in_ready  (dn_in_ready),
        .in_num    (i_num_reg),
        .in_den    (i_den_reg),
        .in_side   (i_side_reg),
        .out_valid (dn_out_valid),
        .out_ready (j_rdy),
        .out_q     (dn_q),
        .out_ovf   (dn_ovf),
        .out_side  (dn_side)
    );

    always_comb
    begin
        dn_bad = dn_side[N_SIDE_W-1];
        dn_sel = dn_side[N_SIDE_W-2:N_SIDE_W-4];
        for (int l = 0; l < 3; l++)
        begin
            dn_c[l] = q_t'(dn_side[l*QW +: QW]);
            // The maximum lane overflows and is overridden; non-positive lanes give zero.
            if (dn_sel[l])
                j_val[l] = QONE;
            else if (dn_sel != 3'b000)
                j_val[l] = (dn_c[l] > 0 && !dn_ovf[l]) ? q_t'({4'b0, dn_q[l]}) : '0;
            else
                j_val[l] = dn_c[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (j_rdy && dn_out_valid)
        begin
            for (int l = 0; l < 3; l++)
            begin
                j_zero_reg[l] <= dn_bad || (j_val[l] <= 0);
                j_over_reg[l] <= !dn_bad && (j_val[l] > QONE);
                j_frac_reg[l] <= j_val[l][QF:0];
            end
            j_bad_reg <= dn_bad;
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            k_prod[l] = IP_W'(j_frac_reg[l]) * IP_W'(LUT_TOP) + IP_W'(1 << (QF - 1));
    end

    always_ff @(posedge clk)
    begin
        if (k_rdy && j_v_reg)
        begin
            for (int l = 0; l < 3; l++)
                k_idx_reg[l] <= k_prod[l][QF+ADDR_W-1:QF];
            k_zero_reg <= j_zero_reg;
            k_over_reg <= j_over_reg;
            k_bad_reg <= j_bad_reg;
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_rom
        cxr_gamma_rom #(
            .DEPTH  (GAMMA_LUT_DEPTH),
            .ADDR_W (ADDR_W)
        ) u_rom (
            .clk  (clk),
            .en   (l_rdy && k_v_reg),
            .addr (k_idx_reg[ch]),
            .data (l_data[ch])
        );
    end

    always_ff @(posedge clk)
    begin
        if (l_rdy && k_v_reg)
        begin
            l_zero_reg <= k_zero_reg;
            l_over_reg <= k_over_reg;
            l_bad_reg <= k_bad_reg;
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            out_ch[l] = l_zero_reg[l] ? 8'd0 : (l_over_reg[l] ? 8'd255 : l_data[l]);
    end

    assign m_tvalid = l_v_reg;
    assign m_tdata = {out_ch[2], out_ch[1], out_ch[0]};
    assign m_tuser = l_bad_reg;

    // A bad-coordinate result must come with all three channels at zero.
    `CXR_ASSERT_SAME(a_bad_black, m_tvalid && m_tuser[0], m_tdata == 24'd0,
        "bad coordinate result is not black")

    // With nothing waiting at the output every stage can move, so input is taken.
    `CXR_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready,
        "input blocked while the output is empty")

    // A channel is never both forced to zero and to full scale.
    `CXR_ASSERT_SAME(a_flags_exclusive, k_v_reg, (k_zero_reg & k_over_reg) == 3'b000,
        "channel flagged both zero and saturated")

endmodule
